// ===== rtl/core/cjl_pkg.sv =====
// ----------------------------------------------------------------------------
// cjl_pkg: shared types and constants for the CSV to JSON lines converter
// Character codes, error and register codes, and the result-group type that
// collects the bytes and status of one input beat, with helpers that append
// the fixed output strings.
// ----------------------------------------------------------------------------
package cjl_pkg;

   // Widest expansion of one input beat is six bytes plus a status item.
   localparam int MaxBytes   = 6;
   localparam int NbWidth    = 3;
   localparam int CsrAddrW   = 2;
   localparam int ReqDataW   = 8;
   localparam int RspDataW   = 144;
   localparam int RspUserW   = 2;

   // Character codes.
   localparam logic [7:0] CH_HT     = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LOW_L  = 8'h6C;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_DEL    = 8'h7F;

   // Error codes reported in a status item.
   localparam logic [2:0] ERR_NONE         = 3'd0;
   localparam logic [2:0] ERR_STRAY_QUOTE  = 3'd1;
   localparam logic [2:0] ERR_EMPTY_LINE   = 3'd2;
   localparam logic [2:0] ERR_OPEN_QUOTE   = 3'd3;
   localparam logic [2:0] ERR_EMPTY_INPUT  = 3'd4;

   // Configuration register indexes.
   localparam logic [CsrAddrW-1:0] CSR_SKIP_BEFORE = 2'd0;
   localparam logic [CsrAddrW-1:0] CSR_SKIP_AFTER  = 2'd1;
   localparam logic [CsrAddrW-1:0] CSR_ALLOW_EMPTY = 2'd2;
   localparam logic [CsrAddrW-1:0] CSR_EMPTY_NULL  = 2'd3;

   // All results caused by one input beat.
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [NbWidth-1:0]       nbytes;
      logic                     status;
      logic [2:0]               err;
      logic [31:0]              rec;
      logic [31:0]              fld;
      logic [31:0]              lin;
      logic [31:0]              chr;
      logic [2:0]               pstate;
   } grp_type;

   function automatic grp_type put(input grp_type g, input logic [7:0] b);
      grp_type r;
      r = g;
      r.bytes[r.nbytes] = b;
      r.nbytes = r.nbytes + NbWidth'(1);
      return r;
   endfunction

   function automatic grp_type put_null(input grp_type g);
      grp_type r;
      r = put(g, CH_LOW_N);
      r = put(r, CH_LOW_U);
      r = put(r, CH_LOW_L);
      r = put(r, CH_LOW_L);
      return r;
   endfunction

   // "[null,"
   function automatic grp_type put_null_first(input grp_type g);
      return put(put_null(put(g, CH_LBRACK)), CH_COMMA);
   endfunction

   // "null,"
   function automatic grp_type put_null_mid(input grp_type g);
      return put(put_null(g), CH_COMMA);
   endfunction

   // "null]\n"
   function automatic grp_type put_null_end(input grp_type g);
      return put(put(put_null(g), CH_RBRACK), CH_LF);
   endfunction

   // Text for an empty line: "null\n" or "[]\n".
   function automatic grp_type put_empty(input grp_type g, input logic as_null);
      grp_type r;
      if (as_null) begin
         r = put(put_null(g), CH_LF);
      end else begin
         r = put(put(put(g, CH_LBRACK), CH_RBRACK), CH_LF);
      end
      return r;
   endfunction

   // "\"]\n"
   function automatic grp_type put_close(input grp_type g);
      return put(put(put(g, CH_QUOTE), CH_RBRACK), CH_LF);
   endfunction

   // Ordinary field character with backslash and tab escaped.
   function automatic grp_type put_escaped(input grp_type g, input logic [7:0] c);
      grp_type r;
      if (c == CH_BSLASH) begin
         r = put(put(g, CH_BSLASH), CH_BSLASH);
      end else if (c == CH_HT) begin
         r = put(put(g, CH_BSLASH), CH_LOW_T);
      end else begin
         r = put(g, c);
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/csv_to_json_lines_converter.sv =====
// ----------------------------------------------------------------------------
// csv_to_json_lines_converter: CSV byte stream to line-delimited JSON arrays
// Parses RFC 4180 style CSV one byte per beat and produces one JSON array per
// record, with saturating record, field, line and character counters and a
// status beat on errors and at the end of the stream.
// ----------------------------------------------------------------------------
//
// Channel | Direction | Beat carries
// --------+-----------+--------------------------------------------------------
// req_*   | in        | one CSV byte, or the end of the stream when req_tlast
// rsp_*   | out       | one JSON byte, or a status item (tuser says which)
// csr_*   | in        | write of one 1-bit configuration register
//
// The parser takes one request beat per cycle while req_tready is high. All
// the work for a beat is done in the cycle it is accepted and lands in a
// result group of up to seven beats; the response side sends one beat per
// cycle while rsp_tready is high. Two result groups are buffered (one
// sending, one waiting), so a request is taken while a finished result
// still waits on rsp_tready. Reset is synchronous and active high; it returns
// the parser to the start of a record and all configuration registers to 1.
//
module csv_to_json_lines_converter #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request stream.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [cjl_pkg::ReqDataW-1:0]   req_tdata,  // [7:0] in_byte
   input  logic                           req_tlast,  // end_of_input
   // Response stream.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] out_byte, [10:8] error_code, [42:11] record_number,
   // [74:43] field_number, [106:75] line_number, [138:107] char_number,
   // [141:139] parse_state, [143:142] zero
   output logic [cjl_pkg::RspDataW-1:0]   rsp_tdata,
   output logic [cjl_pkg::RspUserW-1:0]   rsp_tuser,  // [0] byte_valid, [1] status_valid
   output logic                           rsp_tlast,  // last
   // Configuration writes.
   input  logic                           csr_we,
   input  logic [cjl_pkg::CsrAddrW-1:0]   csr_addr,
   input  logic                           csr_wdata
);
   import cjl_pkg::*;

   // Parser states; the encoding is the reported parse_state.
   typedef enum logic [2:0] {
      ST_REC = 3'd0,
      ST_FLD = 3'd1,
      ST_PLN = 3'd2,
      ST_QUO = 3'd3,
      ST_CLS = 3'd4
   } pstate_type;

   localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);
   localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

   // Saturating increment of a counter.
   function automatic logic [COUNT_WIDTH-1:0] inc(input logic [COUNT_WIDTH-1:0] v);
      return (v != CountMax) ? v + CountOne : v;
   endfunction

   // Counter as reported: clipped to 32 bits.
   function automatic logic [31:0] rep(input logic [COUNT_WIDTH-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return (w[63:32] != 32'd0) ? 32'hFFFF_FFFF : w[31:0];
   endfunction

   // Configuration registers.
   logic skip_before_ff;
   logic skip_after_ff;
   logic allow_empty_ff;
   logic empty_null_ff;

   // Stream state.
   pstate_type             state_ff,  state_in;
   logic                   halted_ff, halted_in;
   logic [2:0]             err_ff,    err_in;
   logic [COUNT_WIDTH-1:0] rec_ff,    rec_in;
   logic [COUNT_WIDTH-1:0] fld_ff,    fld_in;
   logic [COUNT_WIDTH-1:0] lin_ff,    lin_in;
   logic [COUNT_WIDTH-1:0] chr_ff,    chr_in;

   // Result groups: A is being sent, B waits behind it.
   grp_type              grp_in;
   grp_type              a_ff;
   grp_type              b_ff;
   logic                 a_valid_ff;
   logic                 b_valid_ff;
   logic [NbWidth-1:0]   rd_ptr_ff;

   logic                 req_fire;
   logic                 rsp_fire;
   logic                 grp_has;
   logic [NbWidth-1:0]   a_total;
   logic                 a_last;
   logic                 a_free;
   logic                 is_byte;

   logic [7:0]           c;
   logic                 ignore_c;
   logic                 blank_c;
   pstate_type           eff_state;
   logic [2:0]           step_err;

   assign req_tready = !b_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign c          = req_tdata[7:0];
   assign blank_c    = (c == CH_SPACE) || (c == CH_HT);

   // -------------------------------------------------------------------------
   // Parser: next stream state and the result group of the accepted beat.
   // -------------------------------------------------------------------------
   always_comb begin
      grp_in    = '0;
      state_in  = state_ff;
      halted_in = halted_ff;
      err_in    = err_ff;
      rec_in    = rec_ff;
      fld_in    = fld_ff;
      lin_in    = lin_ff;
      chr_in    = chr_ff;
      eff_state = state_ff;
      step_err  = ERR_NONE;
      ignore_c  = 1'b0;

      if (req_tlast) begin
         // End of stream: flush the open record, then report status.
         if (!halted_ff) begin
            case (state_ff)
               ST_REC: begin
                  if (chr_ff == '0) begin
                     if (allow_empty_ff) begin
                        grp_in = put_empty(grp_in, empty_null_ff);
                     end else begin
                        rec_in = '0;
                        fld_in = '0;
                        lin_in = '0;
                        err_in = ERR_EMPTY_INPUT;
                     end
                  end
               end
               ST_FLD: begin
                  grp_in = put_null_end(grp_in);
               end
               ST_QUO: begin
                  grp_in = put_close(grp_in);
                  err_in = ERR_OPEN_QUOTE;
               end
               default: begin
                  grp_in = put_close(grp_in);
               end
            endcase
         end
         grp_in.status = 1'b1;
         grp_in.err    = err_in;
         grp_in.rec    = rep(rec_in);
         grp_in.fld    = rep(fld_in);
         grp_in.lin    = rep(lin_in);
         grp_in.chr    = rep(chr_in);
         grp_in.pstate = state_ff;
         // The whole stream state returns to its reset values.
         state_in  = ST_REC;
         halted_in = 1'b0;
         err_in    = ERR_NONE;
         rec_in    = CountOne;
         fld_in    = CountOne;
         lin_in    = CountOne;
         chr_in    = '0;
      end else if (!halted_ff) begin
         chr_in   = inc(chr_ff);
         ignore_c = ((c < CH_SPACE) || (c == CH_DEL)) && (c != CH_LF) && (c != CH_HT)
                    && !((c == CH_CR) && (state_ff == ST_QUO));
         if (!ignore_c) begin
            // At the start of a record anything but LF or comma opens the
            // array and is then handled as at the start of a field.
            if (state_ff == ST_REC) begin
               if (c == CH_LF) begin
                  lin_in = inc(lin_ff);
                  if (allow_empty_ff) begin
                     rec_in = inc(rec_ff);
                     grp_in = put_empty(grp_in, empty_null_ff);
                  end else begin
                     step_err = ERR_EMPTY_LINE;
                  end
               end else if (c == CH_COMMA) begin
                  fld_in   = inc(fld_ff);
                  grp_in   = put_null_first(grp_in);
                  state_in = ST_FLD;
               end else begin
                  grp_in    = put(grp_in, CH_LBRACK);
                  state_in  = ST_FLD;
                  eff_state = ST_FLD;
               end
            end

            case (eff_state)
               ST_FLD: begin
                  if (!(skip_before_ff && blank_c)) begin
                     if (c == CH_COMMA) begin
                        fld_in = inc(fld_ff);
                        grp_in = put_null_mid(grp_in);
                     end else if (c == CH_LF) begin
                        grp_in   = put_null_end(grp_in);
                        lin_in   = inc(lin_ff);
                        rec_in   = inc(rec_ff);
                        fld_in   = CountOne;
                        state_in = ST_REC;
                     end else if (c == CH_QUOTE) begin
                        grp_in   = put(grp_in, CH_QUOTE);
                        state_in = ST_QUO;
                     end else begin
                        grp_in   = put_escaped(put(grp_in, CH_QUOTE), c);
                        state_in = ST_PLN;
                     end
                  end
               end
               ST_PLN: begin
                  if (c == CH_COMMA) begin
                     fld_in   = inc(fld_ff);
                     grp_in   = put(put(grp_in, CH_QUOTE), CH_COMMA);
                     state_in = ST_FLD;
                  end else if (c == CH_LF) begin
                     grp_in   = put_close(grp_in);
                     lin_in   = inc(lin_ff);
                     rec_in   = inc(rec_ff);
                     fld_in   = CountOne;
                     state_in = ST_REC;
                  end else if (c == CH_QUOTE) begin
                     grp_in = put(put(grp_in, CH_BSLASH), CH_QUOTE);
                  end else begin
                     grp_in = put_escaped(grp_in, c);
                  end
               end
               ST_QUO: begin
                  if (c == CH_LF) begin
                     lin_in = inc(lin_ff);
                     grp_in = put(put(grp_in, CH_BSLASH), CH_LOW_N);
                  end else if (c == CH_CR) begin
                     grp_in = put(put(grp_in, CH_BSLASH), CH_LOW_R);
                  end else if (c == CH_QUOTE) begin
                     state_in = ST_CLS;
                  end else begin
                     grp_in = put_escaped(grp_in, c);
                  end
               end
               ST_CLS: begin
                  if (!(skip_after_ff && blank_c)) begin
                     if (c == CH_COMMA) begin
                        fld_in   = inc(fld_ff);
                        grp_in   = put(put(grp_in, CH_QUOTE), CH_COMMA);
                        state_in = ST_FLD;
                     end else if (c == CH_LF) begin
                        grp_in   = put_close(grp_in);
                        lin_in   = inc(lin_ff);
                        rec_in   = inc(rec_ff);
                        fld_in   = CountOne;
                        state_in = ST_REC;
                     end else if (c == CH_QUOTE) begin
                        // A doubled quote stands for one literal quote.
                        grp_in   = put(put(grp_in, CH_BSLASH), CH_QUOTE);
                        state_in = ST_QUO;
                     end else begin
                        step_err = ERR_STRAY_QUOTE;
                     end
                  end
               end
               default: begin
                  // Start of record already handled above.
               end
            endcase
         end

         // An error closes an open quoted field, reports and halts.
         if (step_err != ERR_NONE) begin
            err_in    = step_err;
            halted_in = 1'b1;
            if (state_in == ST_CLS) begin
               grp_in = put_close(grp_in);
            end
            grp_in.status = 1'b1;
            grp_in.err    = step_err;
            grp_in.rec    = rep(rec_in);
            grp_in.fld    = rep(fld_in);
            grp_in.lin    = rep(lin_in);
            grp_in.chr    = rep(chr_in);
            grp_in.pstate = state_in;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stream state and configuration registers.
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_REC;
         halted_ff      <= 1'b0;
         err_ff         <= ERR_NONE;
         rec_ff         <= CountOne;
         fld_ff         <= CountOne;
         lin_ff         <= CountOne;
         chr_ff         <= '0;
         skip_before_ff <= 1'b1;
         skip_after_ff  <= 1'b1;
         allow_empty_ff <= 1'b1;
         empty_null_ff  <= 1'b1;
      end else begin
         if (req_fire) begin
            state_ff  <= state_in;
            halted_ff <= halted_in;
            err_ff    <= err_in;
            rec_ff    <= rec_in;
            fld_ff    <= fld_in;
            lin_ff    <= lin_in;
            chr_ff    <= chr_in;
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_SKIP_BEFORE: skip_before_ff <= csr_wdata;
               CSR_SKIP_AFTER:  skip_after_ff  <= csr_wdata;
               CSR_ALLOW_EMPTY: allow_empty_ff <= csr_wdata;
               CSR_EMPTY_NULL:  empty_null_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result buffering and the response stream.
   // -------------------------------------------------------------------------
   assign grp_has  = req_fire && ((grp_in.nbytes != '0) || grp_in.status);
   assign a_total  = a_ff.nbytes + NbWidth'(a_ff.status);
   assign a_last   = (rd_ptr_ff == a_total - NbWidth'(1));
   assign rsp_fire = rsp_tvalid && rsp_tready;
   // Group A can take new contents when empty or when its last beat leaves.
   assign a_free   = !a_valid_ff || (rsp_fire && a_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         rd_ptr_ff  <= '0;
      end else if (a_free) begin
         rd_ptr_ff <= '0;
         if (b_valid_ff) begin
            a_valid_ff <= 1'b1;
            b_valid_ff <= 1'b0;
         end else begin
            a_valid_ff <= grp_has;
         end
      end else begin
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + NbWidth'(1);
         end
         if (grp_has) begin
            b_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_free) begin
         a_ff <= b_valid_ff ? b_ff : grp_in;
      end
      if (!a_free && grp_has) begin
         b_ff <= grp_in;
      end
   end

   // Bytes come first; the status item, if any, is the final beat.
   assign is_byte    = (rd_ptr_ff < a_ff.nbytes);
   assign rsp_tvalid = a_valid_ff;
   assign rsp_tlast  = a_last;
   assign rsp_tuser  = {!is_byte, is_byte};
   assign rsp_tdata  = is_byte
                       ? {{(RspDataW - 8){1'b0}}, a_ff.bytes[rd_ptr_ff]}
                       : {2'b00, a_ff.pstate, a_ff.chr, a_ff.lin, a_ff.fld, a_ff.rec,
                          a_ff.err, 8'h00};

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the CSV to JSON lines converter
// Feeds CSV byte streams and end-of-input beats through the request channel,
// predicts every JSON byte and status beat with a behavioural model of the
// parser, and checks the response channel beat by beat under varying idling,
// backpressure and register settings.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cjl_pkg::*;

   // SETTLE_CYCLES is the settling time allowed after the last result before a
   // register write or the end.
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 300;

   typedef enum logic [2:0] {
      PS_RECORD  = 3'd0,
      PS_FIELD   = 3'd1,
      PS_PLAIN   = 3'd2,
      PS_QUOTED  = 3'd3,
      PS_CLOSING = 3'd4
   } parse_state_type;

   // One request beat: a CSV byte or the end of the stream.
   typedef struct packed {
      logic [7:0] ch;
      logic       eoi;
   } csv_item_type;

   // One response beat, split into its fields.
   typedef struct packed {
      logic [7:0]  ch;
      logic        bv;
      logic        sv;
      logic        last;
      logic [2:0]  err;
      logic [31:0] rec;
      logic [31:0] fld;
      logic [31:0] lin;
      logic [31:0] chr;
      logic [2:0]  pst;
   } json_beat_type;

   // -------------------------------------------------------------------------
   // Clock, reset and the block's ports. Every input has a known value from
   // time zero.
   // -------------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ReqDataW-1:0]   req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RspDataW-1:0]   rsp_tdata;
   logic [RspUserW-1:0]   rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CsrAddrW-1:0]   csr_addr   = '0;
   logic                  csr_wdata  = 1'b0;

   always #10 clock = ~clock;

   csv_to_json_lines_converter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Bench bookkeeping.
   // -------------------------------------------------------------------------
   csv_item_type  csv_pending_q[$];   // beats waiting to be offered
   json_beat_type json_expect_q[$];   // predicted response beats, oldest first
   json_beat_type beat_results_q[$];  // results of the beat being predicted

   int items_queued       = 0;
   int items_taken        = 0;
   int docs_made          = 0;
   int fail_count         = 0;
   int bytes_seen         = 0;
   int status_seen        = 0;
   int err_seen[5]        = '{default: 0};
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_requests      = 0;

   // -------------------------------------------------------------------------
   // Parser model: its own copy of the registers and of the stream state.
   // -------------------------------------------------------------------------
   logic         cfg_skip_before = 1'b1;
   logic         cfg_skip_after  = 1'b1;
   logic         cfg_allow_empty = 1'b1;
   logic         cfg_empty_null  = 1'b1;

   parse_state_type pst    = PS_RECORD;
   logic         halted_q  = 1'b0;
   logic [2:0]   err_q     = ERR_NONE;
   logic [31:0]  rec_cnt   = 32'd1;
   logic [31:0]  fld_cnt   = 32'd1;
   logic [31:0]  lin_cnt   = 32'd1;
   logic [31:0]  chr_cnt   = 32'd0;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_HT);
   endfunction

   function automatic void push_byte(input logic [7:0] b);
      json_beat_type e;
      e    = '0;
      e.ch = b;
      e.bv = 1'b1;
      beat_results_q.push_back(e);
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endfunction

   function automatic void push_empty_line();
      if (cfg_empty_null) begin
         push_text("null\n");
      end else begin
         push_text("[]\n");
      end
   endfunction

   // Backslash and tab are escaped, everything else goes through raw.
   function automatic void push_escaped(input logic [7:0] c);
      if (c == CH_BSLASH) begin
         push_byte(CH_BSLASH);
         push_byte(CH_BSLASH);
      end else if (c == CH_HT) begin
         push_byte(CH_BSLASH);
         push_byte(CH_LOW_T);
      end else begin
         push_byte(c);
      end
   endfunction

   function automatic void push_status();
      json_beat_type e;
      e     = '0;
      e.sv  = 1'b1;
      e.err = err_q;
      e.rec = rec_cnt;
      e.fld = fld_cnt;
      e.lin = lin_cnt;
      e.chr = chr_cnt;
      e.pst = pst;
      beat_results_q.push_back(e);
   endfunction

   function automatic void close_record();
      lin_cnt = sat_inc(lin_cnt);
      rec_cnt = sat_inc(rec_cnt);
      fld_cnt = 32'd1;
      pst     = PS_RECORD;
   endfunction

   function automatic void restart_stream();
      pst      = PS_RECORD;
      halted_q = 1'b0;
      err_q    = ERR_NONE;
      rec_cnt  = 32'd1;
      fld_cnt  = 32'd1;
      lin_cnt  = 32'd1;
      chr_cnt  = 32'd0;
   endfunction

   // Runs one character through the state machine and returns an error code.
   function automatic logic [2:0] parse_char(input logic [7:0] c);
      // Control characters are dropped, apart from LF, HT and a CR that sits
      // inside a quoted field.
      if ((c < CH_SPACE || c == CH_DEL) && c != CH_LF && c != CH_HT
          && !(c == CH_CR && pst == PS_QUOTED)) return ERR_NONE;
      if (pst == PS_RECORD) begin
         if (c == CH_LF) begin
            lin_cnt = sat_inc(lin_cnt);
            if (!cfg_allow_empty) return ERR_EMPTY_LINE;
            rec_cnt = sat_inc(rec_cnt);
            push_empty_line();
            return ERR_NONE;
         end
         if (c == CH_COMMA) begin
            fld_cnt = sat_inc(fld_cnt);
            push_text("[null,");
            pst = PS_FIELD;
            return ERR_NONE;
         end
         // Any other character opens the array and is then handled as the
         // first character of a field.
         push_byte(CH_LBRACK);
         pst = PS_FIELD;
      end
      case (pst)
         PS_FIELD: begin
            if (cfg_skip_before && is_blank(c)) return ERR_NONE;
            if (c == CH_COMMA) begin
               fld_cnt = sat_inc(fld_cnt);
               push_text("null,");
            end else if (c == CH_LF) begin
               push_text("null]\n");
               close_record();
            end else if (c == CH_QUOTE) begin
               push_byte(CH_QUOTE);
               pst = PS_QUOTED;
            end else begin
               push_byte(CH_QUOTE);
               push_escaped(c);
               pst = PS_PLAIN;
            end
         end
         PS_PLAIN: begin
            if (c == CH_COMMA) begin
               fld_cnt = sat_inc(fld_cnt);
               push_byte(CH_QUOTE);
               push_byte(CH_COMMA);
               pst = PS_FIELD;
            end else if (c == CH_LF) begin
               push_text("\"]\n");
               close_record();
            end else if (c == CH_QUOTE) begin
               push_byte(CH_BSLASH);
               push_byte(CH_QUOTE);
            end else begin
               push_escaped(c);
            end
         end
         PS_QUOTED: begin
            if (c == CH_LF) begin
               lin_cnt = sat_inc(lin_cnt);
               push_byte(CH_BSLASH);
               push_byte(CH_LOW_N);
            end else if (c == CH_CR) begin
               push_byte(CH_BSLASH);
               push_byte(CH_LOW_R);
            end else if (c == CH_QUOTE) begin
               pst = PS_CLOSING;
            end else begin
               push_escaped(c);
            end
         end
         default: begin
            // After a closing quote only a separator, a line end or a second
            // quote (an escaped quote) may follow.
            if (cfg_skip_after && is_blank(c)) return ERR_NONE;
            if (c == CH_COMMA) begin
               fld_cnt = sat_inc(fld_cnt);
               push_byte(CH_QUOTE);
               push_byte(CH_COMMA);
               pst = PS_FIELD;
            end else if (c == CH_LF) begin
               push_text("\"]\n");
               close_record();
            end else if (c == CH_QUOTE) begin
               push_byte(CH_BSLASH);
               push_byte(CH_QUOTE);
               pst = PS_QUOTED;
            end else begin
               return ERR_STRAY_QUOTE;
            end
         end
      endcase
      return ERR_NONE;
   endfunction

   // Works out every response beat that one accepted request beat causes and
   // appends them to the expectation queue.
   function automatic void convert_beat(input logic [7:0] c, input logic eoi);
      logic [2:0] code;
      beat_results_q.delete();
      if (eoi) begin
         if (!halted_q) begin
            case (pst)
               PS_RECORD: begin
                  if (chr_cnt == '0) begin
                     if (cfg_allow_empty) begin
                        push_empty_line();
                     end else begin
                        rec_cnt = '0;
                        fld_cnt = '0;
                        lin_cnt = '0;
                        err_q   = ERR_EMPTY_INPUT;
                     end
                  end
               end
               PS_FIELD: push_text("null]\n");
               PS_QUOTED: begin
                  push_text("\"]\n");
                  err_q = ERR_OPEN_QUOTE;
               end
               default: push_text("\"]\n");
            endcase
         end
         push_status();
         restart_stream();
      end else if (!halted_q) begin
         chr_cnt = sat_inc(chr_cnt);
         code    = parse_char(c);
         if (code != ERR_NONE) begin
            err_q    = code;
            halted_q = 1'b1;
            if (pst == PS_CLOSING) push_text("\"]\n");
            push_status();
         end
      end
      if (beat_results_q.size() > 0) beat_results_q[$].last = 1'b1;
      foreach (beat_results_q[i]) json_expect_q.push_back(beat_results_q[i]);
   endfunction

   // -------------------------------------------------------------------------
   // Request driver. Once a beat is offered it stays on the bus until it is
   // taken; each signal gets a single assignment per edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      csv_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            convert_beat(req_tdata, req_tlast);
            items_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (csv_pending_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               nxt = csv_pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.ch;
               req_tlast  <= nxt.eoi;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response sink. Besides random stalls it can hold off for a long stretch
   // on request, counting the cycles itself, so that the block's buffers fill
   // up and it has to push back on the request side.
   // -------------------------------------------------------------------------
   int hold_left  = 0;
   int holds_done = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holds_done != hold_requests) begin
         holds_done++;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Response monitor: every accepted beat is checked against the oldest
   // prediction, field by field.
   // -------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      json_beat_type got;
      json_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ch   = rsp_tdata[7:0];
         got.err  = rsp_tdata[10:8];
         got.rec  = rsp_tdata[42:11];
         got.fld  = rsp_tdata[74:43];
         got.lin  = rsp_tdata[106:75];
         got.chr  = rsp_tdata[138:107];
         got.pst  = rsp_tdata[141:139];
         got.bv   = rsp_tuser[0];
         got.sv   = rsp_tuser[1];
         got.last = rsp_tlast;
         if (got.bv) bytes_seen++;
         if (got.sv) begin
            status_seen++;
            if (got.err <= ERR_EMPTY_INPUT) err_seen[got.err]++;
         end
         if (json_expect_q.size() == 0) begin
            $display("%0t ns: response beat with nothing expected, expected none, actual %h/%h",
                     $time, rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            want = json_expect_q.pop_front();
            check_field("out_byte",      32'(want.ch),   32'(got.ch));
            check_field("byte_valid",    32'(want.bv),   32'(got.bv));
            check_field("status_valid",  32'(want.sv),   32'(got.sv));
            check_field("last",          32'(want.last), 32'(got.last));
            check_field("error_code",    32'(want.err),  32'(got.err));
            check_field("record_number", want.rec,       got.rec);
            check_field("field_number",  want.fld,       got.fld);
            check_field("line_number",   want.lin,       got.lin);
            check_field("char_number",   want.chr,       got.chr);
            check_field("parse_state",   32'(want.pst),  32'(got.pst));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers.
   // -------------------------------------------------------------------------
   task automatic add_item(input logic [7:0] ch, input logic eoi);
      csv_item_type it;
      it.ch  = ch;
      it.eoi = eoi;
      csv_pending_q.push_back(it);
      items_queued++;
   endtask

   // The byte beside an end-of-input beat is don't-care, so it is random.
   task automatic add_eoi();
      add_item(8'($urandom_range(255)), 1'b1);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b0);
   endtask

   function automatic logic [7:0] plain_char();
      case ($urandom_range(15))
         0:       return CH_BSLASH;
         1:       return CH_HT;
         2:       return 8'($urandom_range(128, 255));
         3:       return ($urandom_range(5) == 0) ? CH_QUOTE : CH_SPACE;
         4:       return ($urandom_range(1) == 0) ? CH_DEL : 8'($urandom_range(31));
         default: return 8'($urandom_range(8'h30, 8'h7A));
      endcase
   endfunction

   function automatic logic [7:0] quoted_char();
      case ($urandom_range(15))
         0:       return CH_COMMA;
         1:       return CH_LF;
         2:       return CH_CR;
         3:       return CH_BSLASH;
         4:       return CH_HT;
         5:       return 8'($urandom_range(128, 255));
         6:       return 8'($urandom_range(31));
         default: return 8'($urandom_range(8'h20, 8'h7E));
      endcase
   endfunction

   // One field: empty, plain or quoted, with the odd blank around it. Now and
   // then a quoted field is left open, which runs on to an open-quote error.
   task automatic gen_field();
      int kind;
      int len;
      kind = $urandom_range(9);
      if ($urandom_range(4) == 0) add_item(($urandom_range(1) != 0) ? CH_SPACE : CH_HT, 1'b0);
      if (kind >= 6) begin
         add_item(CH_QUOTE, 1'b0);
         len = $urandom_range(5);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(7) == 0) begin
               add_item(CH_QUOTE, 1'b0);
               add_item(CH_QUOTE, 1'b0);
            end else begin
               add_item(quoted_char(), 1'b0);
            end
         end
         if ($urandom_range(15) != 0) add_item(CH_QUOTE, 1'b0);
         if ($urandom_range(4) == 0) add_item(CH_SPACE, 1'b0);
      end else if (kind >= 2) begin
         len = $urandom_range(1, 5);
         for (int i = 0; i < len; i++) add_item(plain_char(), 1'b0);
      end
   endtask

   // A whole CSV document: a few records of a few fields, with empty lines,
   // a sprinkling of arbitrary bytes, sometimes no final line end, and always
   // the end-of-input beat.
   task automatic gen_document();
      int n_rec;
      int n_fld;
      n_rec = $urandom_range(4);
      docs_made++;
      for (int r = 0; r < n_rec; r++) begin
         n_fld = $urandom_range(4);
         for (int f = 0; f < n_fld; f++) begin
            if (f > 0) add_item(CH_COMMA, 1'b0);
            gen_field();
         end
         if ($urandom_range(19) == 0) add_item(8'($urandom_range(255)), 1'b0);
         if (r < n_rec - 1 || $urandom_range(3) != 0) add_item(CH_LF, 1'b0);
      end
      add_eoi();
   endtask

   // Waits until every queued beat has been taken and every predicted result
   // has arrived, then lets the block settle.
   task automatic wait_drained();
      while (items_taken != items_queued || json_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes happen only while the block is drained.
   task automatic write_reg(input logic [CsrAddrW-1:0] idx, input logic val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_SKIP_BEFORE: cfg_skip_before = val;
         CSR_SKIP_AFTER:  cfg_skip_after  = val;
         CSR_ALLOW_EMPTY: cfg_allow_empty = val;
         default:         cfg_empty_null  = val;
      endcase
   endtask

   task automatic set_config(input logic sb, input logic sa, input logic ae, input logic en);
      write_reg(CSR_SKIP_BEFORE, sb);
      write_reg(CSR_SKIP_AFTER,  sa);
      write_reg(CSR_ALLOW_EMPTY, ae);
      write_reg(CSR_EMPTY_NULL,  en);
   endtask

   // One random phase. Half way through, the sender waits for every result
   // to come back before it carries on.
   task automatic run_phase(input int idle_pct, input int stall_pct, input logic hold,
                            input logic sb, input logic sa, input logic ae,
                            input logic en, input int n_items);
      int start;
      set_config(sb, sa, ae, en);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      if (hold) hold_requests++;
      start = items_queued;
      while (items_queued - start < n_items / 2) gen_document();
      wait_drained();
      while (items_queued - start < n_items) gen_document();
      wait_drained();
   endtask

   // -------------------------------------------------------------------------
   // Test sequence.
   // -------------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset settings. An empty stream comes first.
      add_eoi();
      // Leading comma, skipped blank, quoted field holding CR, LF and an
      // escaped quote, blank after the closing quote, then a plain field with
      // a dropped NUL, a high byte, backslash, inner quote, tab and a dropped
      // DEL.
      add_text(", \"q");
      add_item(CH_CR, 1'b0);
      add_item(CH_LF, 1'b0);
      add_text("\"\"\" ,");
      add_item(8'h00, 1'b0);
      add_item(8'hFF, 1'b0);
      add_text("\\\"");
      add_item(CH_HT, 1'b0);
      add_item(CH_DEL, 1'b0);
      add_item(CH_LF, 1'b0);
      // An empty line, then a stray character after a closing quote; the
      // byte after the error is ignored while the block is halted.
      add_item(CH_LF, 1'b0);
      add_text("\"a\"bc");
      add_eoi();
      // A quoted field still open at the end of the stream.
      add_text("\"x");
      add_eoi();
      wait_drained();

      // Empty lines refused: an empty line, then an empty stream.
      set_config(1'b1, 1'b1, 1'b0, 1'b0);
      add_item(CH_LF, 1'b0);
      add_text("z");
      add_eoi();
      add_eoi();
      wait_drained();

      // Random part: each idling pattern in turn, with the registers at both
      // extremes and in mixed settings. The last phase stalls the response
      // side for a long stretch while the sender keeps offering.
      run_phase(0,  0,  1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 30);
      run_phase(60, 0,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 30);
      run_phase(0,  60, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 30);
      run_phase(18, 18, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 30);
      run_phase(0,  0,  1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'b1, 1'($urandom_range(1)), 30);

      wait_drained();
      $display("Run covered %0d CSV beats in %0d random documents plus directed streams,",
               items_taken, docs_made);
      $display("giving %0d JSON bytes and %0d status beats (codes 0-4 seen: %0d %0d %0d %0d %0d).",
               bytes_seen, status_seen, err_seen[0], err_seen[1], err_seen[2],
               err_seen[3], err_seen[4]);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
